// File: sv/sld_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sld_pkg: shared types and constants of the frame deframer
// record kinds, the record layout and the framing constants
// ----------------------------------------------------------------------------
package sld_pkg;

  localparam logic [7:0] START_BYTE  = 8'hFE;
  localparam logic [7:0] MAX_LEN_RST = 8'd250;

  typedef enum logic [1:0] {
    KIND_HEADER   = 2'd0,
    KIND_PAYLOAD  = 2'd1,
    KIND_FRAME_END = 2'd2,
    KIND_LEN_LONG = 2'd3
  } rec_kind_e;

  typedef struct packed {
    rec_kind_e   kind;
    logic [7:0]  frame_len;
    logic [15:0] command_word;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_index;
    logic        check_ok;
    logic        last;
  } rec_t;

endpackage
`default_nettype wire

// File: sv/sld_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sld_if: byte and record channels of the frame deframer
// valid/ready channels with a source and a sink side
// ----------------------------------------------------------------------------
interface sld_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface sld_rec_if;
  logic        valid;
  logic        ready;
  logic [1:0]  rec_kind;
  logic [7:0]  frame_len;
  logic [15:0] command_word;
  logic [7:0]  payload_byte;
  logic [7:0]  payload_index;
  logic        check_ok;
  logic        last;

  modport source (output valid, output rec_kind, output frame_len, output command_word,
                  output payload_byte, output payload_index, output check_ok,
                  output last, input ready);
  modport sink (input valid, input rec_kind, input frame_len, input command_word,
                input payload_byte, input payload_index, input check_ok,
                input last, output ready);
endinterface
`default_nettype wire

// File: sv/sld_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sld_parser: frame phase tracking and record formation
// consumes one byte per accept and forms at most one record from it
// ----------------------------------------------------------------------------
module sld_parser
  import sld_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       take_i,
  input  wire logic [7:0] byte_i,
  input  wire logic [7:0] max_len_i,
  output logic            rec_valid_o,
  output rec_t            rec_o
);

  typedef enum logic [2:0] {
    PH_HUNT  = 3'd0,
    PH_LEN   = 3'd1,
    PH_CMD0  = 3'd2,
    PH_CMD1  = 3'd3,
    PH_DATA  = 3'd4,
    PH_CHECK = 3'd5
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [7:0] len_q, len_d;
  logic [7:0] cmd0_q, cmd0_d;
  logic [7:0] cmd1_q, cmd1_d;
  logic [7:0] cnt_q, cnt_d;
  logic [7:0] xor_q, xor_d;
  logic       has_rec;
  logic [8:0] cnt_inc;

  assign cnt_inc = {1'b0, cnt_q} + 9'd1;

  always_comb begin
    phase_d = phase_q;
    len_d   = len_q;
    cmd0_d  = cmd0_q;
    cmd1_d  = cmd1_q;
    cnt_d   = cnt_q;
    xor_d   = xor_q;
    has_rec = 1'b0;
    rec_o   = '{kind: KIND_HEADER, frame_len: len_q, command_word: {cmd1_q, cmd0_q},
                payload_byte: 8'd0, payload_index: 8'd0, check_ok: 1'b0, last: 1'b0};
    unique case (phase_q)
      PH_LEN: begin
        len_d = byte_i;
        rec_o.frame_len = byte_i;
        if (byte_i > max_len_i) begin
          has_rec            = 1'b1;
          rec_o.kind         = KIND_LEN_LONG;
          rec_o.command_word = 16'd0;
          rec_o.last         = 1'b1;
          phase_d            = PH_HUNT;
        end else begin
          xor_d   = byte_i;
          phase_d = PH_CMD0;
        end
      end
      PH_CMD0: begin
        cmd0_d  = byte_i;
        xor_d   = xor_q ^ byte_i;
        phase_d = PH_CMD1;
      end
      PH_CMD1: begin
        cmd1_d             = byte_i;
        xor_d              = xor_q ^ byte_i;
        cnt_d              = 8'd0;
        has_rec            = 1'b1;
        rec_o.command_word = {byte_i, cmd0_q};
        phase_d            = (len_q == 8'd0) ? PH_CHECK : PH_DATA;
      end
      PH_DATA: begin
        has_rec             = 1'b1;
        rec_o.kind          = KIND_PAYLOAD;
        rec_o.payload_byte  = byte_i;
        rec_o.payload_index = cnt_q;
        xor_d               = xor_q ^ byte_i;
        cnt_d               = cnt_inc[7:0];
        if (cnt_inc >= {1'b0, len_q}) begin
          phase_d = PH_CHECK;
        end
      end
      PH_CHECK: begin
        has_rec        = 1'b1;
        rec_o.kind     = KIND_FRAME_END;
        rec_o.check_ok = (byte_i == xor_q);
        rec_o.last     = 1'b1;
        phase_d        = PH_HUNT;
      end
      default: begin
        phase_d = (byte_i == START_BYTE) ? PH_LEN : PH_HUNT;
      end
    endcase
  end

  assign rec_valid_o = take_i && has_rec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      len_q   <= 8'd0;
      cmd0_q  <= 8'd0;
      cmd1_q  <= 8'd0;
      cnt_q   <= 8'd0;
      xor_q   <= 8'd0;
    end else if (take_i) begin
      phase_q <= phase_d;
      len_q   <= len_d;
      cmd0_q  <= cmd0_d;
      cmd1_q  <= cmd1_d;
      cnt_q   <= cnt_d;
      xor_q   <= xor_d;
    end
  end

endmodule
`default_nettype wire

// File: sv/sld_skid.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sld_skid: output register with skid stage
// takes one more record while the sink stalls
// ----------------------------------------------------------------------------
module sld_skid
  import sld_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire rec_t in_data_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output rec_t      out_data_o
);

  logic main_valid_q;
  logic skid_valid_q;
  rec_t main_q;
  rec_t skid_q;

  assign in_ready_o  = !skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_ready_i || !main_valid_q) begin
      if (skid_valid_q) begin
        main_valid_q <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        main_valid_q <= in_valid_i;
      end
    end else if (in_valid_i && !skid_valid_q) begin
      skid_valid_q <= 1'b1;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (out_ready_i || !main_valid_q) begin
      main_q <= skid_valid_q ? skid_q : in_data_i;
    end else if (in_valid_i && !skid_valid_q) begin
      skid_q <= in_data_i;
    end
  end

endmodule
`default_nettype wire

// File: sv/sof_len_cmd_xor_deframer_top.sv
`timescale 1ns / 1ps
`default_nettype none
// a record is held in the output register, or first in the skid entry if the sink stalls
// throughput: one byte per cycle unless stalled; parser state is updated every accept
// while the sink stalls, bytes keep flowing until one more record lands in the skid
// entry, then ready drops
// reset: parser hunts for the start byte, all captured fields cleared, limit set to 250
// ----------------------------------------------------------------------------
// sof_len_cmd_xor_deframer_top: start/length/command/xor frame deframer
// parses received bytes into header, payload and frame-end records
// ----------------------------------------------------------------------------
module sof_len_cmd_xor_deframer_top
  import sld_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [7:0] cfg_wdata_i,
  sld_byte_if.sink        rx_i,
  sld_rec_if.source       rec_o
);

  // payload length limit, compared only when the length byte arrives
  logic [7:0] max_len_q;

  // request handshake toward the parser
  logic take;
  logic skid_ready;
  logic rec_valid;
  rec_t rec;
  rec_t out_rec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MAX_LEN_RST;
    end else if (cfg_we_i) begin
      max_len_q <= cfg_wdata_i;
    end
  end

  // bytes are taken whenever the skid stage has room, even if no record results
  assign rx_i.ready = skid_ready;
  assign take       = rx_i.valid && skid_ready;

  sld_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .byte_i      (rx_i.rx_byte),
    .max_len_i   (max_len_q),
    .rec_valid_o (rec_valid),
    .rec_o       (rec)
  );

  // output register plus skid entry
  sld_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (rec_valid),
    .in_ready_o  (skid_ready),
    .in_data_i   (rec),
    .out_valid_o (rec_o.valid),
    .out_ready_i (rec_o.ready),
    .out_data_o  (out_rec)
  );

  assign rec_o.rec_kind      = out_rec.kind;
  assign rec_o.frame_len     = out_rec.frame_len;
  assign rec_o.command_word  = out_rec.command_word;
  assign rec_o.payload_byte  = out_rec.payload_byte;
  assign rec_o.payload_index = out_rec.payload_index;
  assign rec_o.check_ok      = out_rec.check_ok;
  assign rec_o.last          = out_rec.last;

  // a stalled skid entry means the output register is holding a record
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !skid_ready |-> rec_o.valid)
    else $error("skid entry held while output register empty");

  // payload index stays below the frame length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_valid && rec.kind == KIND_PAYLOAD |-> rec.payload_index < rec.frame_len)
    else $error("payload index beyond frame length");

  // frame end and length-too-long records close the frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_valid && (rec.kind == KIND_FRAME_END || rec.kind == KIND_LEN_LONG) |-> rec.last)
    else $error("closing record without last mark");

  // a record is only formed from an accepted byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_valid |-> take)
    else $error("record formed without an accepted byte");

endmodule
`default_nettype wire
